>>> sv/utx_pkg.sv
// shared types, constants and register codes for the uart transmitter
// no dependencies; compiled first

package utx_pkg;

  // transmit queue and bit timing
  localparam int QUEUE_DEPTH = 8;
  localparam int OVERSAMPLE  = 16;

  localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_W    = 16;
  localparam int TICK_W   = 20;
  localparam int PERIOD_W = DIV_W + 1 + $clog2(OVERSAMPLE + 1);
  localparam int FRAME_W  = 12;
  localparam int BITS_W   = 4;
  localparam int DATA_W   = 8;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BAUD_DIVISOR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_STOP_BITS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = CFG_IDX_W'(3);

  // parity modes
  localparam logic [1:0] PAR_NONE = 2'b00;
  localparam logic [1:0] PAR_EVEN = 2'b01;
  localparam logic [1:0] PAR_ODD  = 2'b10;

  // input opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic {
    CMD_TICK,
    CMD_WRITE
  } cmd_kind_t;

  // classified transaction handed from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic [DATA_W-1:0] data;
  } cmd_t;

endpackage

>>> sv/utx_if.sv
// channel interfaces: input transactions, results and configuration writes
// depends on utx_pkg

interface utx_in_if;
  import utx_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface utx_out_if;
  logic valid;
  logic ready;
  logic tx_line;
  logic buffer_full;
  logic write_dropped;
  logic busy_res;

  modport source (output valid, output tx_line, output buffer_full,
                  output write_dropped, output busy_res, input ready);
  modport sink   (input valid, input tx_line, input buffer_full,
                  input write_dropped, input busy_res, output ready);
endinterface

interface utx_cfg_if;
  import utx_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/uart_transmitter_with_fifo.sv
// top level of the uart transmitter with transmit queue
// depends on utx_pkg, utx_if, utx_front, utx_back

// uart transmitter, 8 data bits lsb first, parity none/even/odd, one or two
// stop bits. each input transaction is either one peripheral tick or a byte
// write into an eight-entry transmit queue, and each gives exactly one result
// transaction: line level, queue-full flag, dropped-write flag and busy flag.
// a bit lasts 16*(baud_divisor+1) ticks; a write to a full queue is dropped.
// throughput is one transaction per clock: the front end decodes transactions
// into a two-entry command queue, the back end executes one command per cycle
// (its combinational tick/load update is the loop that sets this rate) and a
// registered result stage lets a new command run in the same cycle that the
// previous result is taken; while a result waits untaken the back end stalls
// and the command queue absorbs up to two more transactions.
// from input to result a transaction passes the command queue, then the result stage.
// configuration writes (index 0 divisor, 1 parity, 2 stop bits, 3 enable)
// are always taken and belong in idle periods; clearing enable aborts the
// current frame but keeps the queued bytes.

module uart_transmitter_with_fifo (
  input  logic      clk,
  input  logic      rst_n,
  utx_in_if.sink    in_if,
  utx_out_if.source out_if,
  utx_cfg_if.sink   cfg_if
);
  import utx_pkg::*;

  // command queue between front and back
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  utx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  utx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .cfg_if    (cfg_if),
    .out_if    (out_if)
  );

endmodule

>>> sv/utx_front.sv
// front end: accepts input transactions, decodes the opcode and holds them
// in a two-entry command queue for the back end; depends on utx_pkg, utx_if

module utx_front (
  input  logic          clk,
  input  logic          rst_n,
  utx_in_if.sink        in_if,
  output logic          cmd_valid,
  output utx_pkg::cmd_t cmd,
  input  logic          cmd_ready
);
  import utx_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.kind = (in_if.op == OP_WRITE) ? CMD_WRITE : CMD_TICK;
    cmd_in.data = in_if.data_byte;
  end

  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

>>> sv/utx_back.sv
// back end: configuration registers, byte queue, frame shifter, bit timer
// and the registered result stage; depends on utx_pkg, utx_if

module utx_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  utx_pkg::cmd_t cmd,
  output logic          cmd_ready,
  utx_cfg_if.sink       cfg_if,
  utx_out_if.source     out_if
);
  import utx_pkg::*;

  // configuration
  logic [DIV_W-1:0] baud_div_r;
  logic [1:0]       parity_mode_r;
  logic             two_stop_r;
  logic             enable_r;
  logic             cfg_wr;

  // byte queue
  logic [DATA_W-1:0] q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt, head_inc, wr_idx;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W:0]    wr_sum;
  logic              q_wr;

  // frame
  logic [FRAME_W-1:0]  shift_r, shift_nxt, load_frame;
  logic [BITS_W-1:0]   bits_r, bits_nxt, load_len;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [PERIOD_W-1:0] period, tick_inc;
  logic [DATA_W-1:0]   head_byte;
  logic                has_par, par_bit;

  // result stage
  logic out_valid_r;
  logic tx_line_r, buffer_full_r, write_dropped_r, busy_r;
  logic pop, dropped;

  assign cfg_if.ready = 1'b1;
  assign cfg_wr       = cfg_if.valid;

  assign cmd_ready = !out_valid_r || out_if.ready;
  assign pop       = cmd_valid && cmd_ready;

  // bit time and tick counter
  assign period   = (PERIOD_W'(baud_div_r) + PERIOD_W'(1)) * PERIOD_W'(OVERSAMPLE);
  assign tick_inc = PERIOD_W'(tick_r) + PERIOD_W'(1);

  // queue addressing
  assign wr_sum   = (CNT_W+1)'(head_r) + (CNT_W+1)'(count_r);
  assign wr_idx   = (wr_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                    ? PTR_W'(wr_sum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(wr_sum);
  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);

  // next frame from the queue head: start, data lsb first, parity, stops
  assign head_byte  = q_mem[head_r];
  assign has_par    = (parity_mode_r == PAR_EVEN) || (parity_mode_r == PAR_ODD);
  assign par_bit    = (^head_byte) ^ (parity_mode_r == PAR_ODD);
  assign load_frame = {2'b11, (has_par ? par_bit : 1'b1), head_byte, 1'b0};
  assign load_len   = BITS_W'(10) + BITS_W'(two_stop_r) + BITS_W'(has_par);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    tick_nxt  = tick_r;
    dropped   = 1'b0;
    q_wr      = 1'b0;
    if (pop) begin
      if (cmd.kind == CMD_WRITE) begin
        if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
          dropped = 1'b1;
        end else begin
          q_wr      = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end else if (enable_r) begin
        if (bits_r != '0) begin
          if (tick_inc >= period) begin
            tick_nxt  = '0;
            shift_nxt = {1'b1, shift_r[FRAME_W-1:1]};
            bits_nxt  = bits_r - BITS_W'(1);
          end else begin
            tick_nxt = tick_inc[TICK_W-1:0];
          end
        end
        // back-to-back frames: reload in the tick that ends the last stop bit
        if (bits_nxt == '0 && count_r != '0) begin
          shift_nxt = load_frame;
          bits_nxt  = load_len;
          tick_nxt  = '0;
          head_nxt  = head_inc;
          count_nxt = count_r - CNT_W'(1);
        end
      end
    end
    // disabling aborts the frame in progress, queue kept
    if (cfg_wr && cfg_if.index == CFG_ENABLE && !cfg_if.data[0]) begin
      shift_nxt = '1;
      bits_nxt  = '0;
      tick_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baud_div_r    <= '0;
      parity_mode_r <= PAR_NONE;
      two_stop_r    <= 1'b0;
      enable_r      <= 1'b0;
      head_r        <= '0;
      count_r       <= '0;
      shift_r       <= '1;
      bits_r        <= '0;
      tick_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_if.index)
          CFG_BAUD_DIVISOR:  baud_div_r    <= cfg_if.data[DIV_W-1:0];
          CFG_PARITY_MODE:   parity_mode_r <= cfg_if.data[1:0];
          CFG_TWO_STOP_BITS: two_stop_r    <= cfg_if.data[0];
          CFG_ENABLE:        enable_r      <= cfg_if.data[0];
          default: ;
        endcase
      end
      head_r  <= head_nxt;
      count_r <= count_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      tick_r  <= tick_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload and queue storage, no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      tx_line_r       <= (enable_r && bits_nxt != '0) ? shift_nxt[0] : 1'b1;
      buffer_full_r   <= (count_nxt >= CNT_W'(QUEUE_DEPTH));
      write_dropped_r <= dropped;
      busy_r          <= (bits_nxt != '0);
    end
    if (q_wr) begin
      q_mem[wr_idx] <= cmd.data;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.tx_line       = tx_line_r;
  assign out_if.buffer_full   = buffer_full_r;
  assign out_if.write_dropped = write_dropped_r;
  assign out_if.busy_res      = busy_r;

endmodule

>>> test/utx_line_checker.sv
// line checker for the uart transmitter: predicts every result transaction and compares
// depends on utx_pkg and the channel interfaces in utx_if

module utx_line_checker (
  input  logic clk,
  input  logic rst_n,
  utx_in_if    in_if,
  utx_out_if   out_if,
  utx_cfg_if   cfg_if,
  output int   mismatches,
  output int   awaiting
);
  import utx_pkg::*;

  typedef struct packed {
    logic tx_line;
    logic buffer_full;
    logic write_dropped;
    logic busy_res;
  } line_status_t;

  line_status_t line_status_q[$];

  // private copy of the transmitter state
  logic [DATA_W-1:0]  fifo_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   fifo_head;
  logic [CNT_W-1:0]   fifo_count;
  logic [FRAME_W-1:0] shifter;
  logic [BITS_W-1:0]  bits_to_send;
  logic [TICK_W-1:0]  bit_ticks;

  logic [DIV_W-1:0]   divisor;
  logic [1:0]         parity;
  logic               two_stop;
  logic               enabled;

  int result_no;

  task automatic clear_frame();
    shifter      = '1;
    bits_to_send = '0;
    bit_ticks    = '0;
  endtask

  task automatic load_next_frame();
    logic [DATA_W-1:0]  b;
    logic [FRAME_W-1:0] f;
    logic               p;
    int                 len;
    b   = fifo_mem[fifo_head];
    f   = {3'b111, b, 1'b0};
    len = 10 + int'(two_stop);
    if (parity == PAR_EVEN || parity == PAR_ODD) begin
      p    = ^b;
      if (parity == PAR_ODD) p = ~p;
      f[9] = p;
      len  = len + 1;
    end
    shifter      = f;
    bits_to_send = BITS_W'(len);
    bit_ticks    = '0;
    fifo_head    = PTR_W'((int'(fifo_head) + 1) % QUEUE_DEPTH);
    fifo_count   = fifo_count - 1'b1;
  endtask

  task automatic advance_transmitter(input logic op, input logic [DATA_W-1:0] b,
                                     output line_status_t st);
    int unsigned period;
    int unsigned next_ticks;
    logic        dropped;
    dropped = 1'b0;
    if (op == OP_WRITE) begin
      if (int'(fifo_count) >= QUEUE_DEPTH) begin
        dropped = 1'b1;
      end else begin
        fifo_mem[(int'(fifo_head) + int'(fifo_count)) % QUEUE_DEPTH] = b;
        fifo_count = fifo_count + 1'b1;
      end
    end else if (enabled) begin
      period     = OVERSAMPLE * (int'(divisor) + 1);
      next_ticks = bit_ticks + 1;
      if (bits_to_send != 0) begin
        // a bit whose count already passed a shortened bit time ends here
        if (next_ticks >= period) begin
          bit_ticks    = '0;
          shifter      = {1'b1, shifter[FRAME_W-1:1]};
          bits_to_send = bits_to_send - 1'b1;
        end else begin
          bit_ticks = TICK_W'(next_ticks);
        end
      end
      if (bits_to_send == 0 && fifo_count != 0) load_next_frame();
    end
    st.tx_line       = (enabled && bits_to_send != 0) ? shifter[0] : 1'b1;
    st.buffer_full   = int'(fifo_count) >= QUEUE_DEPTH;
    st.write_dropped = dropped;
    st.busy_res      = bits_to_send != 0;
  endtask

  always @(posedge clk) begin
    line_status_t want, got;
    if (!rst_n) begin
      line_status_q.delete();
      fifo_head  = '0;
      fifo_count = '0;
      clear_frame();
      divisor    = '0;
      parity     = PAR_NONE;
      two_stop   = 1'b0;
      enabled    = 1'b0;
      result_no  = 0;
      mismatches = 0;
    end else begin
      // results first: a result never belongs to the transaction of the same edge
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.tx_line, out_if.buffer_full, out_if.write_dropped, out_if.busy_res};
        if (line_status_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected: line=%b full=%b drop=%b busy=%b",
                     result_no, got.tx_line, got.buffer_full, got.write_dropped, got.busy_res);
        end else begin
          want = line_status_q.pop_front();
          if (got != want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("result %0d: expected line=%b full=%b drop=%b busy=%b, got %b %b %b %b",
                       result_no, want.tx_line, want.buffer_full, want.write_dropped,
                       want.busy_res, got.tx_line, got.buffer_full, got.write_dropped,
                       got.busy_res);
          end
        end
        result_no = result_no + 1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_BAUD_DIVISOR:  divisor  = cfg_if.data[DIV_W-1:0];
          CFG_PARITY_MODE:   parity   = cfg_if.data[1:0];
          CFG_TWO_STOP_BITS: two_stop = cfg_if.data[0];
          CFG_ENABLE: begin
            enabled = cfg_if.data[0];
            if (!enabled) clear_frame();
          end
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        advance_transmitter(in_if.op, in_if.data_byte, want);
        line_status_q.push_back(want);
      end
    end
    awaiting = line_status_q.size();
  end

endmodule

>>> test/uart_transmitter_with_fifo_tb.sv
// testbench top for uart_transmitter_with_fifo: clock, reset, stimulus and verdict
// depends on utx_pkg, utx_if, the rtl and utx_line_checker

module uart_transmitter_with_fifo_tb;
  import utx_pkg::*;

  // cycles without any transaction on any channel before the run is declared hung
  localparam int STALL_LIMIT = 1000;
  // cycles allowed after the last expected result
  localparam int TAIL_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic no_gaps;
  int   mismatches;
  int   awaiting;
  int   quiet_cycles;

  utx_in_if  in_ch ();
  utx_out_if out_ch ();
  utx_cfg_if cfg_ch ();

  uart_transmitter_with_fifo u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  utx_line_checker u_line_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_if     (cfg_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side back-pressure, dropped during the no-gap stretch
  always @(negedge clk) begin
    out_ch.ready <= no_gaps || ($urandom_range(99) >= 32);
  end

  // watchdog: any accepted transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("uart_transmitter_with_fifo_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transaction: random idle cycles first, then hold valid until taken
  task automatic send_item(input logic op, input logic [DATA_W-1:0] b);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    while (!no_gaps && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // register write, only once every outstanding result has come back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // random burst: mostly ticks so frames make progress, writes at the given rate
  task automatic run_burst(input int n, input int write_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < write_pct)
        send_item(OP_WRITE, DATA_W'($urandom));
      else
        send_item(OP_TICK, DATA_W'($urandom));
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    no_gaps          = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_TICK;
    in_ch.data_byte  = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_BAUD_DIVISOR;
    cfg_ch.data      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // enabled with an empty queue: line stays high, not busy
    write_reg(CFG_ENABLE, 16'd1);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'hFF);
    // disabled: writes still queue, ticks do nothing
    write_reg(CFG_ENABLE, 16'd0);
    send_item(OP_WRITE, 8'h00);
    send_item(OP_TICK, 8'h5A);
    // even parity, two stop bits, fastest bit time; first tick loads the frame
    write_reg(CFG_PARITY_MODE, 16'(PAR_EVEN));
    write_reg(CFG_TWO_STOP_BITS, 16'd1);
    write_reg(CFG_BAUD_DIVISOR, 16'd0);
    write_reg(CFG_ENABLE, 16'd1);
    send_item(OP_TICK, 8'h00);
    // fill the queue to its depth, then one more write which must be dropped
    send_item(OP_WRITE, 8'hFF);
    send_item(OP_WRITE, 8'h80);
    send_item(OP_WRITE, 8'h01);
    send_item(OP_WRITE, 8'h55);
    send_item(OP_WRITE, 8'hAA);
    send_item(OP_WRITE, 8'h7F);
    send_item(OP_WRITE, 8'hFE);
    send_item(OP_WRITE, 8'h3C);
    send_item(OP_WRITE, 8'hC3);
    repeat (4) send_item(OP_TICK, 8'h00);
    // slowest bit time
    write_reg(CFG_BAUD_DIVISOR, 16'hFFFF);
    repeat (3) send_item(OP_TICK, 8'hFF);

    // ---- random part ----
    // back to the fast rate, even parity and two stop bits
    write_reg(CFG_BAUD_DIVISOR, 16'd0);
    run_burst(160, 3);
    // odd parity, one stop bit, no idling on either side
    write_reg(CFG_PARITY_MODE, 16'(PAR_ODD));
    write_reg(CFG_TWO_STOP_BITS, 16'd0);
    no_gaps = 1'b1;
    run_burst(160, 3);
    no_gaps = 1'b0;
    // slowest rate mid-frame, then a short bit time the count already passed
    write_reg(CFG_BAUD_DIVISOR, 16'hFFFF);
    run_burst(60, 5);
    write_reg(CFG_BAUD_DIVISOR, 16'd1);
    // parity mode three behaves as no parity
    write_reg(CFG_PARITY_MODE, 16'd3);
    write_reg(CFG_TWO_STOP_BITS, 16'd1);
    run_burst(160, 4);
    // abort the frame; writes go to a full queue and get dropped
    write_reg(CFG_ENABLE, 16'd0);
    run_burst(40, 30);
    // arbitrary divisor in between the extremes
    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_BAUD_DIVISOR, 16'($urandom_range(2, 65534)));
    run_burst(40, 5);
    // plain 8n1 at the fastest rate
    write_reg(CFG_BAUD_DIVISOR, 16'd0);
    write_reg(CFG_PARITY_MODE, 16'(PAR_NONE));
    write_reg(CFG_TWO_STOP_BITS, 16'd0);
    run_burst(120, 3);

    // drain: wait for every expected result, then a few spare cycles
    @(negedge clk);
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && awaiting == 0) begin
      $display("uart_transmitter_with_fifo_tb: done, clean");
    end else begin
      $display("uart_transmitter_with_fifo_tb: done, errors");
    end
    $finish;
  end

endmodule
